### rtl/core/rfpa_pkg.sv
// Package with shared types, widths, register indexes and datapath operation codes.
package rfpa_pkg;

  localparam int TempW   = 16;
  localparam int TimeW   = 32;
  localparam int BandW   = 12;
  localparam int AmpW    = 7;
  localparam int CountW  = 8;
  localparam int SumW    = 40;
  localparam int GainW   = 32;
  localparam int KuW     = 29;
  localparam int A75W    = 36;
  localparam int MulAW   = 40;
  localparam int MulBW   = 20;
  localparam int MulPW   = MulAW + MulBW;
  localparam int NumW    = 76;
  localparam int DenW    = 48;
  localparam int DivCntW = $clog2(NumW);
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int OpW     = 5;

  // Three fifths as a reciprocal: floor(x * 3 / 5) = (x * Mul3Div5) >> Div5Shift for x below 2^30.
  localparam int Mul3Div5W = 35;
  localparam int Div5Shift = 34;
  localparam logic [Mul3Div5W-1:0] Mul3Div5 = 35'h2_6666_6667;

  localparam logic [MulAW-1:0] PiQ28   = MulAW'(64'd843314857);
  localparam logic [MulAW-1:0] Million = MulAW'(64'd1000000);
  localparam logic [GainW-1:0] GainSat = '1;

  localparam logic [CfgIdxW-1:0] REG_SETPOINT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HYSTERESIS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_AMPLITUDE  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PERIODS    = 2'd3;

  localparam logic [OpW-1:0] OP_NONE    = 5'd0;
  localparam logic [OpW-1:0] OP_SAMPLE  = 5'd1;
  localparam logic [OpW-1:0] OP_SAT_ALL = 5'd2;
  localparam logic [OpW-1:0] OP_MUL_PI  = 5'd3;
  localparam logic [OpW-1:0] OP_DIV_KU  = 5'd4;
  localparam logic [OpW-1:0] OP_KU      = 5'd5;
  localparam logic [OpW-1:0] OP_DIV_P   = 5'd6;
  localparam logic [OpW-1:0] OP_GP      = 5'd7;
  localparam logic [OpW-1:0] OP_IZERO   = 5'd8;
  localparam logic [OpW-1:0] OP_MUL_I1  = 5'd9;
  localparam logic [OpW-1:0] OP_MUL_I2  = 5'd10;
  localparam logic [OpW-1:0] OP_DIV_I   = 5'd11;
  localparam logic [OpW-1:0] OP_GI      = 5'd12;
  localparam logic [OpW-1:0] OP_MUL_D1  = 5'd13;
  localparam logic [OpW-1:0] OP_MUL_DEN = 5'd14;
  localparam logic [OpW-1:0] OP_MUL_D2  = 5'd15;
  localparam logic [OpW-1:0] OP_MUL_D3  = 5'd16;
  localparam logic [OpW-1:0] OP_DIV_D   = 5'd17;
  localparam logic [OpW-1:0] OP_GD      = 5'd18;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic [TimeW-1:0]        time_ms;
    logic                    restart;
  } in_t;

  typedef struct packed {
    logic             relay_on;
    logic             done_res;
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
  } out_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           out_load;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic span_pos;
    logic sum_cnt_ok;
    logic div_busy;
  } status_t;

endpackage

### rtl/core/rfpa_div.sv
// Restoring divider that produces one quotient bit per cycle.
module rfpa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rfpa_pkg::NumW-1:0] num,
  input  logic [rfpa_pkg::DenW-1:0] den,
  output logic                      busy,
  output logic [rfpa_pkg::NumW-1:0] quo
);

  logic [rfpa_pkg::DenW-1:0]    rem;
  logic [rfpa_pkg::DenW-1:0]    dvs;
  logic [rfpa_pkg::DivCntW-1:0] cnt;
  logic [rfpa_pkg::DenW:0]      shifted;
  logic [rfpa_pkg::DenW:0]      diff;
  logic                         ge;

  always_comb begin
    shifted = {rem, quo[rfpa_pkg::NumW-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= rfpa_pkg::DivCntW'(rfpa_pkg::NumW - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? diff[rfpa_pkg::DenW-1:0] : shifted[rfpa_pkg::DenW-1:0];
      quo <= {quo[rfpa_pkg::NumW-2:0], ge};
    end
  end

endmodule

### rtl/core/rfpa_dp.sv
// Datapath with configuration, run state, shared multiplier, divider and output register.
module rfpa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rfpa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rfpa_pkg::CfgW-1:0]    cfg_data,
  input  rfpa_pkg::in_t                in_data,
  input  rfpa_pkg::cmd_t               cmd,
  output rfpa_pkg::status_t            status,
  output rfpa_pkg::out_t               out_data
);

  logic signed [rfpa_pkg::TempW-1:0] setpoint;
  logic [rfpa_pkg::BandW-1:0]        band;
  logic [rfpa_pkg::AmpW-1:0]         amp;
  logic [rfpa_pkg::CountW-1:0]       periods;

  logic                              relay, relay_next;
  logic [rfpa_pkg::CountW-1:0]       count, count_next;
  logic [rfpa_pkg::SumW-1:0]         sum, sum_next;
  logic [rfpa_pkg::TimeW-1:0]        last_on, last_on_next;
  logic                              have_on, have_on_next;
  logic signed [rfpa_pkg::TempW-1:0] temp_high, temp_high_next;
  logic signed [rfpa_pkg::TempW-1:0] temp_low, temp_low_next;
  logic                              done, done_next;
  logic [rfpa_pkg::GainW-1:0]        g0, g0_next, g1, g1_next, g2, g2_next;

  logic [rfpa_pkg::KuW-1:0]          ku;
  logic [rfpa_pkg::A75W-1:0]         a75;
  logic [rfpa_pkg::NumW-1:0]         acc;
  logic [rfpa_pkg::DenW-1:0]         den_r;

  logic signed [rfpa_pkg::TempW:0]   t_x, thr_lo, thr_hi, span;
  logic [rfpa_pkg::TimeW-1:0]        elapsed;
  logic                              finish;
  logic [rfpa_pkg::MulAW-1:0]        mul_a;
  logic [rfpa_pkg::MulBW-1:0]        mul_b;
  logic [rfpa_pkg::MulPW-1:0]        prod;
  logic [rfpa_pkg::KuW+rfpa_pkg::Mul3Div5W-1:0] gp_prod;
  logic                              div_start, div_busy;
  logic [rfpa_pkg::NumW-1:0]         div_num, div_quo;
  logic [rfpa_pkg::DenW-1:0]         div_den;
  logic [rfpa_pkg::GainW-1:0]        quo_clamp;

  rfpa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    span      = {temp_high[rfpa_pkg::TempW-1], temp_high} - {temp_low[rfpa_pkg::TempW-1], temp_low};
    quo_clamp = (|div_quo[rfpa_pkg::NumW-1:rfpa_pkg::GainW]) ? rfpa_pkg::GainSat
                                                           : div_quo[rfpa_pkg::GainW-1:0];
    gp_prod   = ku * rfpa_pkg::Mul3Div5;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      rfpa_pkg::OP_MUL_PI: begin
        mul_a = rfpa_pkg::PiQ28;
        mul_b = rfpa_pkg::MulBW'(span[rfpa_pkg::TempW-1:0]);
      end
      rfpa_pkg::OP_MUL_I1: begin
        mul_a = rfpa_pkg::MulAW'(ku);
        mul_b = rfpa_pkg::MulBW'(1200);
      end
      rfpa_pkg::OP_MUL_I2: begin
        mul_a = acc[rfpa_pkg::MulAW-1:0];
        mul_b = rfpa_pkg::MulBW'(count);
      end
      rfpa_pkg::OP_MUL_D1: begin
        mul_a = rfpa_pkg::MulAW'(ku);
        mul_b = rfpa_pkg::MulBW'(75);
      end
      rfpa_pkg::OP_MUL_DEN: begin
        mul_a = rfpa_pkg::Million;
        mul_b = rfpa_pkg::MulBW'(count);
      end
      rfpa_pkg::OP_MUL_D2: begin
        mul_a = rfpa_pkg::MulAW'(a75);
        mul_b = sum[rfpa_pkg::MulBW-1:0];
      end
      rfpa_pkg::OP_MUL_D3: begin
        mul_a = rfpa_pkg::MulAW'(a75);
        mul_b = sum[rfpa_pkg::SumW-1:rfpa_pkg::MulBW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;

    div_start = 1'b0;
    div_num   = acc;
    div_den   = den_r;
    case (cmd.op)
      rfpa_pkg::OP_DIV_KU: begin
        div_start = 1'b1;
        div_num   = rfpa_pkg::NumW'({amp, 51'b0});
        div_den   = acc[rfpa_pkg::DenW-1:0];
      end
      rfpa_pkg::OP_DIV_I: begin
        div_start = 1'b1;
        div_num   = acc;
        div_den   = rfpa_pkg::DenW'(sum);
      end
      rfpa_pkg::OP_DIV_D: begin
        div_start = 1'b1;
        div_num   = acc;
        div_den   = den_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    relay_next     = relay;
    count_next     = count;
    sum_next       = sum;
    last_on_next   = last_on;
    have_on_next   = have_on;
    temp_high_next = temp_high;
    temp_low_next  = temp_low;
    done_next      = done;
    g0_next        = g0;
    g1_next        = g1;
    g2_next        = g2;
    finish         = 1'b0;
    elapsed        = in_data.time_ms - last_on;
    t_x    = {in_data.temperature[rfpa_pkg::TempW-1], in_data.temperature};
    thr_lo = {setpoint[rfpa_pkg::TempW-1], setpoint} - $signed({5'b0, band});
    thr_hi = {setpoint[rfpa_pkg::TempW-1], setpoint} + $signed({5'b0, band});
    case (cmd.op)
      rfpa_pkg::OP_SAMPLE: begin
        if (in_data.restart) begin
          relay_next     = 1'b0;
          count_next     = '0;
          sum_next       = '0;
          last_on_next   = '0;
          have_on_next   = 1'b0;
          temp_high_next = {1'b1, {(rfpa_pkg::TempW-1){1'b0}}};
          temp_low_next  = {1'b0, {(rfpa_pkg::TempW-1){1'b1}}};
          done_next      = 1'b0;
          g0_next        = '0;
          g1_next        = '0;
          g2_next        = '0;
        end
        if (!done_next) begin
          if (in_data.temperature > temp_high_next) begin
            temp_high_next = in_data.temperature;
          end
          if (in_data.temperature < temp_low_next) begin
            temp_low_next = in_data.temperature;
          end
          if (!relay_next && (t_x < thr_lo)) begin
            relay_next = 1'b1;
            if (have_on_next) begin
              sum_next   = sum_next + rfpa_pkg::SumW'(elapsed);
              count_next = count_next + 1'b1;
            end
            last_on_next = in_data.time_ms;
            have_on_next = 1'b1;
          end else if (relay_next && (t_x > thr_hi)) begin
            relay_next = 1'b0;
          end
          if (count_next >= periods) begin
            finish     = 1'b1;
            relay_next = 1'b0;
            done_next  = 1'b1;
          end
        end
      end
      rfpa_pkg::OP_SAT_ALL: begin
        g0_next = rfpa_pkg::GainSat;
        g1_next = rfpa_pkg::GainSat;
        g2_next = rfpa_pkg::GainSat;
      end
      rfpa_pkg::OP_GP: g0_next = acc[rfpa_pkg::Div5Shift+rfpa_pkg::GainW-1:rfpa_pkg::Div5Shift];
      rfpa_pkg::OP_IZERO: begin
        g1_next = rfpa_pkg::GainSat;
        g2_next = '0;
      end
      rfpa_pkg::OP_GI: g1_next = quo_clamp;
      rfpa_pkg::OP_GD: g2_next = quo_clamp;
      default: begin
        finish = 1'b0;
      end
    endcase

    status.finish     = finish;
    status.span_pos   = span > 0;
    status.sum_cnt_ok = (sum != '0) && (count != '0);
    status.div_busy   = div_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      band     <= rfpa_pkg::BandW'(8);
      amp      <= rfpa_pkg::AmpW'(50);
      periods  <= rfpa_pkg::CountW'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        rfpa_pkg::REG_SETPOINT:   setpoint <= cfg_data;
        rfpa_pkg::REG_HYSTERESIS: band     <= cfg_data[rfpa_pkg::BandW-1:0];
        rfpa_pkg::REG_AMPLITUDE:  amp      <= cfg_data[rfpa_pkg::AmpW-1:0];
        rfpa_pkg::REG_PERIODS:    periods  <= cfg_data[rfpa_pkg::CountW-1:0];
        default:                  periods  <= periods;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay     <= 1'b0;
      count     <= '0;
      sum       <= '0;
      last_on   <= '0;
      have_on   <= 1'b0;
      temp_high <= {1'b1, {(rfpa_pkg::TempW-1){1'b0}}};
      temp_low  <= {1'b0, {(rfpa_pkg::TempW-1){1'b1}}};
      done      <= 1'b0;
      g0        <= '0;
      g1        <= '0;
      g2        <= '0;
    end else begin
      relay     <= relay_next;
      count     <= count_next;
      sum       <= sum_next;
      last_on   <= last_on_next;
      have_on   <= have_on_next;
      temp_high <= temp_high_next;
      temp_low  <= temp_low_next;
      done      <= done_next;
      g0        <= g0_next;
      g1        <= g1_next;
      g2        <= g2_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rfpa_pkg::OP_MUL_PI, rfpa_pkg::OP_MUL_I1, rfpa_pkg::OP_MUL_I2, rfpa_pkg::OP_MUL_D2: begin
        acc <= rfpa_pkg::NumW'(prod);
      end
      rfpa_pkg::OP_DIV_P: acc <= rfpa_pkg::NumW'(gp_prod);
      rfpa_pkg::OP_MUL_D3: acc <= acc + rfpa_pkg::NumW'({prod, 20'b0});
      rfpa_pkg::OP_MUL_D1: a75 <= prod[rfpa_pkg::A75W-1:0];
      rfpa_pkg::OP_MUL_DEN: den_r <= prod[rfpa_pkg::DenW-1:0];
      rfpa_pkg::OP_KU: ku <= div_quo[rfpa_pkg::KuW-1:0];
      default: ku <= ku;
    endcase
    if (cmd.out_load) begin
      out_data.relay_on <= relay_next;
      out_data.done_res <= done_next;
      out_data.gain_p   <= g0_next;
      out_data.gain_i   <= g1_next;
      out_data.gain_d   <= g2_next;
    end
  end

endmodule

### rtl/core/rfpa_ctrl.sv
// Controller state machine that sequences sample handling and the gain computation.
module rfpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rfpa_pkg::status_t status,
  output rfpa_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MUL_PI  = 5'd1;
  localparam logic [4:0] S_DIV_KU  = 5'd2;
  localparam logic [4:0] S_W_KU    = 5'd3;
  localparam logic [4:0] S_DIV_P   = 5'd4;
  localparam logic [4:0] S_W_P     = 5'd5;
  localparam logic [4:0] S_IZERO   = 5'd6;
  localparam logic [4:0] S_MUL_I1  = 5'd7;
  localparam logic [4:0] S_MUL_I2  = 5'd8;
  localparam logic [4:0] S_DIV_I   = 5'd9;
  localparam logic [4:0] S_W_I     = 5'd10;
  localparam logic [4:0] S_MUL_D1  = 5'd11;
  localparam logic [4:0] S_MUL_DEN = 5'd12;
  localparam logic [4:0] S_MUL_D2  = 5'd13;
  localparam logic [4:0] S_MUL_D3  = 5'd14;
  localparam logic [4:0] S_DIV_D   = 5'd15;
  localparam logic [4:0] S_W_D     = 5'd16;
  localparam logic [4:0] S_FIN     = 5'd17;

  logic [4:0] state, state_next;

  always_comb begin
    state_next   = state;
    cmd.op       = rfpa_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.op = rfpa_pkg::OP_SAMPLE;
          if (status.finish) begin
            state_next = S_MUL_PI;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_MUL_PI: begin
        if (status.span_pos) begin
          cmd.op     = rfpa_pkg::OP_MUL_PI;
          state_next = S_DIV_KU;
        end else begin
          cmd.op     = rfpa_pkg::OP_SAT_ALL;
          state_next = S_FIN;
        end
      end
      S_DIV_KU: begin
        cmd.op     = rfpa_pkg::OP_DIV_KU;
        state_next = S_W_KU;
      end
      S_W_KU: begin
        if (!status.div_busy) begin
          cmd.op     = rfpa_pkg::OP_KU;
          state_next = S_DIV_P;
        end
      end
      S_DIV_P: begin
        cmd.op     = rfpa_pkg::OP_DIV_P;
        state_next = S_W_P;
      end
      S_W_P: begin
        if (!status.div_busy) begin
          cmd.op     = rfpa_pkg::OP_GP;
          state_next = status.sum_cnt_ok ? S_MUL_I1 : S_IZERO;
        end
      end
      S_IZERO: begin
        cmd.op     = rfpa_pkg::OP_IZERO;
        state_next = S_FIN;
      end
      S_MUL_I1: begin
        cmd.op     = rfpa_pkg::OP_MUL_I1;
        state_next = S_MUL_I2;
      end
      S_MUL_I2: begin
        cmd.op     = rfpa_pkg::OP_MUL_I2;
        state_next = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.op     = rfpa_pkg::OP_DIV_I;
        state_next = S_W_I;
      end
      S_W_I: begin
        if (!status.div_busy) begin
          cmd.op     = rfpa_pkg::OP_GI;
          state_next = S_MUL_D1;
        end
      end
      S_MUL_D1: begin
        cmd.op     = rfpa_pkg::OP_MUL_D1;
        state_next = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        cmd.op     = rfpa_pkg::OP_MUL_DEN;
        state_next = S_MUL_D2;
      end
      S_MUL_D2: begin
        cmd.op     = rfpa_pkg::OP_MUL_D2;
        state_next = S_MUL_D3;
      end
      S_MUL_D3: begin
        cmd.op     = rfpa_pkg::OP_MUL_D3;
        state_next = S_DIV_D;
      end
      S_DIV_D: begin
        cmd.op     = rfpa_pkg::OP_DIV_D;
        state_next = S_W_D;
      end
      S_W_D: begin
        if (!status.div_busy) begin
          cmd.op     = rfpa_pkg::OP_GD;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/relay_feedback_pid_autotuner.sv
// Top level of the relay feedback autotuner: controller, datapath and port wiring.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   sample   | in_valid, in_ready, in_data           | in
//   result   | out_valid, out_ready, out_data        | out
//   config   | cfg_we, cfg_index, cfg_data           | in
//
// A sample that does not finish the run is handled in the cycle it is taken,
// and its result is registered at the same edge. The sample that finishes a
// run starts the gain computation, with up to three passes of the shared divider.
// When no gain computation is running, a new sample is taken when the result register is empty or is being read.
// Reset is synchronous and restores the register defaults and starts a new run.
module relay_feedback_pid_autotuner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rfpa_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rfpa_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [rfpa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rfpa_pkg::CfgW-1:0]    cfg_data
);

  rfpa_pkg::cmd_t    cmd;
  rfpa_pkg::status_t status;

  rfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rfpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

### dv/relay_feedback_pid_autotuner_test.sv
// Self-checking testbench for the relay feedback PID autotuner with its own gain predictor.
module relay_feedback_pid_autotuner_test;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  rfpa_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rfpa_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [rfpa_pkg::CfgIdxW-1:0] cfg_index = rfpa_pkg::REG_SETPOINT;
  logic [rfpa_pkg::CfgW-1:0]    cfg_data = '0;

  relay_feedback_pid_autotuner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the configuration and run state.
  int               cfg_setpoint;
  int               cfg_band;
  int unsigned      cfg_amp;
  int unsigned      cfg_periods;
  bit               tr_relay;
  bit [7:0]         tr_count;
  bit [39:0]        tr_sum;
  bit [31:0]        tr_last_on;
  bit               tr_have_on;
  int               tr_high;
  int               tr_low;
  bit               tr_done;
  bit [31:0]        tr_gains [3];

  rfpa_pkg::out_t pending_results [$];
  int   errors = 0;
  int   samples_sent = 0;
  int   results_seen = 0;
  int   runs_finished = 0;
  bit   steady = 1'b0;
  int   hold_req = 0;
  bit [31:0] now_ms;

  function automatic bit [31:0] clamp_gain(bit [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task clear_tuning;
    tr_relay = 1'b0;
    tr_count = '0;
    tr_sum = '0;
    tr_last_on = '0;
    tr_have_on = 1'b0;
    tr_high = -32768;
    tr_low = 32767;
    tr_done = 1'b0;
    tr_gains[0] = '0;
    tr_gains[1] = '0;
    tr_gains[2] = '0;
  endtask

  task compute_zn_gains;
    int         span;
    bit [127:0] ku;
    bit [127:0] prod;
    span = tr_high - tr_low;
    if (span <= 0) begin
      tr_gains[0] = rfpa_pkg::GainSat;
      tr_gains[1] = rfpa_pkg::GainSat;
      tr_gains[2] = rfpa_pkg::GainSat;
    end else begin
      ku = (128'(cfg_amp) << 51) / (128'(rfpa_pkg::PiQ28) * 128'(span));
      tr_gains[0] = clamp_gain(ku * 3 / 5);
      if (tr_sum == 0 || tr_count == 0) begin
        tr_gains[1] = rfpa_pkg::GainSat;
        tr_gains[2] = '0;
      end else begin
        tr_gains[1] = clamp_gain(ku * 1200 * 128'(tr_count) / 128'(tr_sum));
        prod = ku * 75 * 128'(tr_sum);
        if (prod > 128'hFFFF_FFFF_FFFF_FFFF) begin
          tr_gains[2] = rfpa_pkg::GainSat;
        end else begin
          tr_gains[2] = clamp_gain(prod / (128'd1000000 * 128'(tr_count)));
        end
      end
    end
  endtask

  task predict_tuner(input rfpa_pkg::in_t s, output rfpa_pkg::out_t r);
    int        t;
    bit [31:0] elapsed;
    t = s.temperature;
    if (s.restart) clear_tuning();
    if (!tr_done) begin
      if (t > tr_high) tr_high = t;
      if (t < tr_low) tr_low = t;
      if (!tr_relay && t < cfg_setpoint - cfg_band) begin
        tr_relay = 1'b1;
        if (tr_have_on) begin
          elapsed = s.time_ms - tr_last_on;
          tr_sum = tr_sum + 40'(elapsed);
          tr_count = tr_count + 8'd1;
        end
        tr_last_on = s.time_ms;
        tr_have_on = 1'b1;
      end else if (tr_relay && t > cfg_setpoint + cfg_band) begin
        tr_relay = 1'b0;
      end
      if (tr_count >= cfg_periods) begin
        compute_zn_gains();
        tr_relay = 1'b0;
        tr_done = 1'b1;
        runs_finished++;
      end
    end
    r.relay_on = tr_relay;
    r.done_res = tr_done;
    r.gain_p = tr_gains[0];
    r.gain_i = tr_gains[1];
    r.gain_d = tr_gains[2];
  endtask

  task send_sample(input int t, input bit [31:0] ts, input bit restart);
    rfpa_pkg::in_t  s;
    rfpa_pkg::out_t r;
    int             gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    s.temperature = 16'(t);
    s.time_ms = ts;
    s.restart = restart;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    predict_tuner(s, r);
    pending_results.push_back(r);
    samples_sent++;
  endtask

  task advance_time;
    now_ms = now_ms + (($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 400));
  endtask

  task drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(input logic [rfpa_pkg::CfgIdxW-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    case (idx)
      rfpa_pkg::REG_SETPOINT:   cfg_setpoint = $signed(16'(value));
      rfpa_pkg::REG_HYSTERESIS: cfg_band = value & 32'hFFF;
      rfpa_pkg::REG_AMPLITUDE:  cfg_amp = value & 32'h7F;
      rfpa_pkg::REG_PERIODS:    cfg_periods = value & 32'hFF;
      default: ;
    endcase
  endtask

  task end_writes;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task configure(input int sp, input int band, input int amp, input int periods);
    drain();
    write_reg(rfpa_pkg::REG_SETPOINT, sp);
    write_reg(rfpa_pkg::REG_HYSTERESIS, band);
    write_reg(rfpa_pkg::REG_AMPLITUDE, amp);
    write_reg(rfpa_pkg::REG_PERIODS, periods);
    end_writes();
  endtask

  // A run: restart, then swing the temperature across the band until done or max_samples.
  task tune_run(input int max_samples);
    int n;
    bit up;
    int t;
    send_sample(sat16(cfg_setpoint), now_ms, 1'b1);
    advance_time();
    n = 0;
    up = 1'b0;
    while (!tr_done && n < max_samples) begin
      if ($urandom_range(0, 7) == 0) begin
        t = cfg_setpoint + $signed($urandom_range(0, 2 * cfg_band)) - cfg_band;
      end else if (!up) begin
        t = cfg_setpoint - cfg_band - 1 - $urandom_range(0, 40);
        up = 1'b1;
      end else begin
        t = cfg_setpoint + cfg_band + 1 + $urandom_range(0, 40);
        up = 1'b0;
      end
      send_sample(sat16(t), now_ms, 1'b0);
      advance_time();
      n++;
    end
    repeat ($urandom_range(1, 3)) begin
      send_sample($signed(16'($urandom)), now_ms, 1'b0);
      advance_time();
    end
  endtask

  task test_directed;
    configure(0, 8, 50, 1);
    send_sample(0, 32'h0, 1'b1);
    send_sample(-32768, 32'hFFFF_FFF0, 1'b0);
    send_sample(32767, 32'hFFFF_FFF8, 1'b0);
    send_sample(-32768, 32'h0000_0010, 1'b0);
    send_sample(100, 32'h0000_0020, 1'b0);
    send_sample(-100, 32'h0000_0030, 1'b0);
    // Exactly on the band edges the relay must not switch.
    send_sample(0, 32'h0, 1'b1);
    send_sample(-8, 32'h64, 1'b0);
    send_sample(-9, 32'hC8, 1'b0);
    send_sample(8, 32'h12C, 1'b0);
    send_sample(9, 32'h190, 1'b0);
    // Two on edges at the same timestamp give a zero period.
    send_sample(-20, 32'h1F4, 1'b1);
    send_sample(20, 32'h1F4, 1'b0);
    send_sample(-20, 32'h1F4, 1'b0);
    // A periods setting of zero finishes on the restart sample with zero span.
    configure(0, 8, 50, 0);
    send_sample(5, 32'h1000, 1'b1);
    send_sample(-50, 32'h1100, 1'b0);
    // Zero relay amplitude.
    configure(0, 8, 0, 1);
    send_sample(-30, 32'h2000, 1'b1);
    send_sample(30, 32'h2064, 1'b0);
    send_sample(-30, 32'h20C8, 1'b0);
    // Lowering the period target in the middle of a run.
    configure(0, 8, 100, 5);
    send_sample(-30, 32'h3000, 1'b1);
    send_sample(30, 32'h3064, 1'b0);
    send_sample(-30, 32'h30C8, 1'b0);
    send_sample(30, 32'h312C, 1'b0);
    send_sample(-30, 32'h3190, 1'b0);
    configure(0, 8, 100, 1);
    send_sample(0, 32'h31F4, 1'b0);
  endtask

  task test_config_sweep;
    int k;
    now_ms = $urandom;
    for (k = 0; k < 60; k++) begin
      steady = ($urandom_range(0, 3) == 0);
      case (k % 10)
        0: configure(-32768, 4095, 100, 1);
        1: configure(32767, 4095, 0, 255);
        2: configure(0, 0, 100, 1);
        3: configure($signed(16'($urandom)), $urandom_range(0, 4095),
                     $urandom_range(0, 127), $urandom_range(0, 10));
        default: configure($signed($urandom_range(0, 2000)) - 1000, $urandom_range(0, 200),
                           $urandom_range(0, 100), $urandom_range(1, 6));
      endcase
      tune_run(40);
    end
    steady = 1'b0;
  endtask

  task test_long_run;
    configure(0, 0, 100, 255);
    now_ms = $urandom;
    tune_run(700);
  endtask

  task test_random_noise;
    int k;
    configure($signed($urandom_range(0, 200)) - 100, $urandom_range(0, 64), 77, 3);
    for (k = 0; k < 300; k++) begin
      send_sample($signed(16'($urandom)), $urandom, ($urandom_range(0, 15) == 0));
    end
  endtask

  task test_backpressure;
    configure(0, 8, 50, 2);
    hold_req = 300;
    now_ms = $urandom;
    tune_run(30);
  endtask

  // Result side: random stalls, an occasional long hold, and the field comparison.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    rfpa_pkg::out_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no expectation, actual %p", $time, out_data);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (e.relay_on !== out_data.relay_on) begin
            $display("%0t: relay_on expected %0b actual %0b", $time, e.relay_on, out_data.relay_on);
            errors++;
          end
          if (e.done_res !== out_data.done_res) begin
            $display("%0t: done_res expected %0b actual %0b", $time, e.done_res, out_data.done_res);
            errors++;
          end
          if (e.gain_p !== out_data.gain_p) begin
            $display("%0t: gain_p expected %h actual %h", $time, e.gain_p, out_data.gain_p);
            errors++;
          end
          if (e.gain_i !== out_data.gain_i) begin
            $display("%0t: gain_i expected %h actual %h", $time, e.gain_i, out_data.gain_i);
            errors++;
          end
          if (e.gain_d !== out_data.gain_d) begin
            $display("%0t: gain_d expected %h actual %h", $time, e.gain_d, out_data.gain_d);
            errors++;
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 4);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #30000000;
    $display("relay_feedback_pid_autotuner_test: errors");
    $finish;
  end

  initial begin
    cfg_setpoint = 0;
    cfg_band = 8;
    cfg_amp = 50;
    cfg_periods = 5;
    clear_tuning();
    now_ms = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_long_run();
    test_random_noise();
    test_backpressure();
    drain();
    $display("Covered %0d sample transfers and %0d result transfers.", samples_sent, results_seen);
    $display("Tuning runs that reached gain computation: %0d.", runs_finished);
    if (errors == 0) begin
      $display("relay_feedback_pid_autotuner_test: clean");
    end else begin
      $display("relay_feedback_pid_autotuner_test: errors");
    end
    $finish;
  end

endmodule
